// ===== rtl/core/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// shared types and codes of the disjoint range tag table
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int AddrPortW = 64;
  localparam int TagPortW  = 16;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  typedef struct packed {
    logic contains;
    logic overlaps;
  } match_t;

endpackage

// ===== rtl/core/drt_match.sv =====
// ----------------------------------------------------------------------------
// drt_match
// range compare unit shared by every step of the table scan
// ----------------------------------------------------------------------------
module drt_match
  import drt_pkg::*;
#(
  parameter int ADDR_WIDTH = 64
) (
  input  logic [ADDR_WIDTH-1:0] entry_low,
  input  logic [ADDR_WIDTH-1:0] entry_high,
  input  logic [ADDR_WIDTH-1:0] query_low,
  input  logic [ADDR_WIDTH-1:0] query_high,
  output match_t                result
);

  always_comb begin
    result.contains = (entry_low <= query_low) && (query_high <= entry_high);
    result.overlaps = (entry_low <= query_high) && (query_low <= entry_high);
  end

endmodule

// ===== rtl/core/disjoint_range_tag_table.sv =====
// ----------------------------------------------------------------------------
// disjoint_range_tag_table
// table of disjoint closed address ranges with a tag on each
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low: cmd, range_low,
// range_high and tag_in. Lookup hits when the query lies wholly inside one
// stored range; delete removes every stored range that overlaps the query;
// set deletes the overlaps and then stores the range in the lowest free slot.
// Each command gives one result beat: done is high for one cycle with hit,
// tag_out and status, and the receiver cannot hold it off.
// A command walks the table one entry a cycle through the single compare
// unit, reading the entry memory at one address per cycle, and busy stays
// high through the result beat, so no new command is taken before done.
// A reversed range or an unused code skips the walk: done is high in the
// cycle right after accept.
// Reset empties the table at once by clearing the valid bits; the entry
// memory itself is left as it is.
// ----------------------------------------------------------------------------
module disjoint_range_tag_table
  import drt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int ADDR_WIDTH = 64,
  parameter int TAG_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [AddrPortW-1:0] range_low,
  input  logic [AddrPortW-1:0] range_high,
  input  logic [TagPortW-1:0]  tag_in,
  output logic                 done,
  output logic                 hit,
  output logic [TagPortW-1:0]  tag_out,
  output logic [1:0]           status
);

  localparam int IdxW  = $clog2(ENTRIES);
  localparam int KeepW = (TAG_WIDTH < TagPortW) ? TAG_WIDTH : TagPortW;

  state_t state, state_next;

  logic [ADDR_WIDTH-1:0] mem_low  [ENTRIES];
  logic [ADDR_WIDTH-1:0] mem_high [ENTRIES];
  logic [KeepW-1:0]      mem_tag  [ENTRIES];
  logic [ENTRIES-1:0]    valid;

  logic [ADDR_WIDTH-1:0] rd_low, rd_high;
  logic [KeepW-1:0]      rd_tag;

  logic [1:0]            cmd_r;
  logic [ADDR_WIDTH-1:0] lo_q, hi_q;
  logic [KeepW-1:0]      tag_q, tag_r;
  logic                  bad_r, found;
  logic [IdxW-1:0]       ptr, cur, slot;

  logic                  accept, bad_in, last, v;
  match_t                m;

  assign accept = start && !busy;
  assign bad_in = (cmd != CMD_NOP) &&
                  (range_low[ADDR_WIDTH-1:0] > range_high[ADDR_WIDTH-1:0]);
  assign last   = (cur == IdxW'(ENTRIES - 1));
  assign v      = valid[cur];

  drt_match #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_match (
    .entry_low  (rd_low),
    .entry_high (rd_high),
    .query_low  (lo_q),
    .query_high (hi_q),
    .result     (m)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (bad_in || cmd == CMD_NOP) ? S_FIN : S_FETCH;
        end
      end
      S_FETCH: state_next = S_SCAN;
      S_SCAN: begin
        if (last) begin
          state_next = S_FIN;
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry memory, registered read at the walk pointer
  always_ff @(posedge clk) begin
    rd_low  <= mem_low[ptr];
    rd_high <= mem_high[ptr];
    rd_tag  <= mem_tag[ptr];
    if (state == S_FIN && cmd_r == CMD_SET && found && !bad_r) begin
      mem_low[slot]  <= lo_q;
      mem_high[slot] <= hi_q;
      mem_tag[slot]  <= tag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            found <= 1'b0;
          end
        end
        S_SCAN: begin
          if ((cmd_r == CMD_SET || cmd_r == CMD_DELETE) && v && m.overlaps) begin
            valid[cur] <= 1'b0;
          end
          if (!found) begin
            if (cmd_r == CMD_LOOKUP && v && m.contains) begin
              found <= 1'b1;
            end
            if (cmd_r == CMD_SET && (!v || m.overlaps)) begin
              found <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (cmd_r == CMD_SET && found && !bad_r) begin
            valid[slot] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command beat capture and walk counters
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
      lo_q  <= range_low[ADDR_WIDTH-1:0];
      hi_q  <= range_high[ADDR_WIDTH-1:0];
      tag_q <= tag_in[KeepW-1:0];
      bad_r <= bad_in;
      ptr   <= '0;
      cur   <= '0;
    end else begin
      if (state == S_FETCH || state == S_SCAN) begin
        ptr <= ptr + 1'b1;
      end
      if (state == S_SCAN) begin
        cur <= cur + 1'b1;
      end
    end
    if (state == S_SCAN && !found) begin
      if (cmd_r == CMD_LOOKUP && v && m.contains) begin
        tag_r <= rd_tag;
      end
      if (cmd_r == CMD_SET && (!v || m.overlaps)) begin
        slot <= cur;
      end
    end
  end

  always_comb begin
    busy    = (state != S_IDLE);
    done    = (state == S_FIN);
    hit     = (cmd_r == CMD_LOOKUP) && found && !bad_r;
    tag_out = hit ? TagPortW'(tag_r) : '0;
    if (bad_r) begin
      status = ST_BAD_RANGE;
    end else if (cmd_r == CMD_SET && !found) begin
      status = ST_FULL;
    end else begin
      status = ST_OK;
    end
  end

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command beat taken but block not busy");

  a_done_release : assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result beat");

  a_hit_status : assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !hit)
    else $error("hit reported with error status");

  a_insert_at_end : assert property (@(posedge clk) disable iff (rst)
    !done |=> $countones(valid) <= $countones($past(valid)))
    else $error("entry added outside the result cycle");

endmodule

// ===== bench/disjoint_range_tag_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disjoint_range_tag_table_tb
// self-checking bench for the disjoint range tag table
// ----------------------------------------------------------------------------
// Drives lookup, set, delete and the unused code through the start/busy
// handshake. A scoreboard keeps its own copy of the range table and predicts
// each result beat. Each done beat is checked field by field against the
// oldest prediction. A directed opening covers the extremes, reversed
// ranges, a full table and overlap removal. Random traffic then follows,
// clustered so that ranges collide, in phases with and without sender gaps.
// ----------------------------------------------------------------------------
module disjoint_range_tag_table_tb
  import drt_pkg::*;
;

  localparam int TableDepth = 16;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;
  localparam int ItemsPerPhase = 362;
  localparam logic [63:0] AddrMax = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        hit;
    logic [15:0] tag;
    logic [1:0]  status;
  } outcome_t;

  class range_table_sb;
    logic [63:0] lows[TableDepth];
    logic [63:0] highs[TableDepth];
    logic [15:0] tags[TableDepth];
    bit          used[TableDepth];
    outcome_t    pending[$];
    int          errors;

    function new();
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void clear_overlaps(logic [63:0] lo, logic [63:0] hi);
      foreach (used[i])
        if (used[i] && lows[i] <= hi && lo <= highs[i]) used[i] = 1'b0;
    endfunction

    function void note_command(logic [1:0] op, logic [63:0] lo, logic [63:0] hi,
                               logic [15:0] tag);
      outcome_t r;
      int slot;
      r = '0;
      slot = -1;
      if (op != CMD_NOP && lo > hi) begin
        r.status = ST_BAD_RANGE;
      end else if (op == CMD_LOOKUP) begin
        for (int i = 0; i < TableDepth; i++) begin
          if (used[i] && lows[i] <= lo && hi <= highs[i]) begin
            r.hit = 1'b1;
            r.tag = tags[i];
            break;
          end
        end
      end else if (op == CMD_SET) begin
        clear_overlaps(lo, hi);
        for (int i = 0; i < TableDepth; i++) begin
          if (!used[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          lows[slot] = lo;
          highs[slot] = hi;
          tags[slot] = tag;
          used[slot] = 1'b1;
        end
      end else if (op == CMD_DELETE) begin
        clear_overlaps(lo, hi);
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic h, logic [15:0] t, logic [1:0] s);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: hit %0d tag_out %h status %0d", h, t, s);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, h);
        errors++;
      end
      if (t !== e.tag) begin
        $error("tag_out: expected %h, got %h", e.tag, t);
        errors++;
      end
      if (s !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = CMD_NOP;
  logic [63:0] range_low = '0;
  logic [63:0] range_high = '0;
  logic [15:0] tag_in = '0;
  logic        busy;
  logic        done;
  logic        hit;
  logic [15:0] tag_out;
  logic [1:0]  status;

  range_table_sb sb;
  int unsigned   cycles = 0;

  disjoint_range_tag_table uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .range_low (range_low),
    .range_high(range_high),
    .tag_in    (tag_in),
    .done      (done),
    .hit       (hit),
    .tag_out   (tag_out),
    .status    (status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[disjoint_range_tag_table] ERROR");
      $finish;
    end
  end

  // accepted command and result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_command(cmd, range_low, range_high, tag_in);
      if (done) sb.check_result(hit, tag_out, status);
    end
  end

  task automatic issue_command(logic [1:0] op, logic [63:0] lo, logic [63:0] hi,
                               logic [15:0] tag, int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    range_low <= lo;
    range_high <= hi;
    tag_in <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_addr();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return 64'($urandom_range(255));
    if (pick < 8) return 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
    return {$urandom, $urandom};
  endfunction

  task automatic random_command(int idle_pct);
    logic [1:0]  op;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    int unsigned pick;
    int          stored[$];
    int          k;
    pick = $urandom_range(99);
    if (pick < 40) op = CMD_LOOKUP;
    else if (pick < 75) op = CMD_SET;
    else if (pick < 93) op = CMD_DELETE;
    else op = CMD_NOP;
    lo = rand_addr();
    span = ($urandom_range(3) == 0) ? ({$urandom, $urandom} >> $urandom_range(63))
                                    : 64'($urandom_range(31));
    hi = lo + span;
    if (hi < lo) hi = AddrMax;
    foreach (sb.used[i]) if (sb.used[i]) stored.push_back(i);
    // aim lookups at stored ranges and their edges
    if (op == CMD_LOOKUP && stored.size() > 0 && $urandom_range(1) == 1) begin
      k = stored[$urandom_range(stored.size() - 1)];
      lo = sb.lows[k];
      hi = sb.highs[k];
      case ($urandom_range(4))
        1: hi = lo;
        2: lo = hi;
        3: lo = lo - 1;
        4: hi = hi + 1;
        default: ;
      endcase
    end
    if ($urandom_range(99) < 5) begin
      if (lo != hi) begin
        span = lo;
        lo = hi;
        hi = span;
      end else if (hi != AddrMax) begin
        lo = hi + 1;
      end
    end
    issue_command(op, lo, hi, 16'($urandom), idle_pct);
  endtask

  task automatic directed_run();
    issue_command(CMD_LOOKUP, 64'd0, AddrMax, 16'hFFFF, 0);
    issue_command(CMD_LOOKUP, AddrMax, 64'd0, 16'h0000, 0);
    issue_command(CMD_SET, AddrMax, 64'd0, 16'hFFFF, 0);
    issue_command(CMD_DELETE, 64'd1, 64'd0, 16'h0000, 0);
    issue_command(CMD_NOP, AddrMax, 64'd0, 16'hFFFF, 0);
    issue_command(CMD_SET, 64'd0, 64'd0, 16'h0000, 0);
    issue_command(CMD_SET, AddrMax, AddrMax, 16'hFFFF, 0);
    for (int i = 1; i <= 14; i++)
      issue_command(CMD_SET, 64'(i) * 64'h100, 64'(i) * 64'h100 + 64'hF, 16'(i), 0);
    // table now full
    issue_command(CMD_SET, 64'h2000, 64'h2000, 16'hA5A5, 0);
    issue_command(CMD_LOOKUP, 64'h310, 64'h315, 16'h0000, 0);
    issue_command(CMD_LOOKUP, 64'h30F, 64'h310, 16'h0000, 0);
    issue_command(CMD_SET, 64'h300, 64'h4FF, 16'h5A5A, 0);
    issue_command(CMD_DELETE, 64'h600, 64'h8FF, 16'h0000, 0);
    issue_command(CMD_LOOKUP, AddrMax, AddrMax, 16'h0000, 0);
  endtask

  initial begin
    int idle_pct[4];
    sb = new();
    idle_pct = '{0, 45, 0, 30};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_run();
    foreach (idle_pct[p])
      for (int n = 0; n < ItemsPerPhase; n++) random_command(idle_pct[p]);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[disjoint_range_tag_table] OK");
    end else begin
      $display("[disjoint_range_tag_table] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/drt_pkg.sv
rtl/core/drt_match.sv
rtl/core/disjoint_range_tag_table.sv
bench/disjoint_range_tag_table_tb.sv
